// ===== hw/rtl/dbl_split_pkg.sv =====
// Shared constants and the decoded-operand stage payload type for the binary64 integer/fraction split.
package dbl_split_pkg;

	localparam int unsigned ExpWidth  = 11;
	localparam int unsigned MantWidth = 52;
	localparam int unsigned WordWidth = 64;
	localparam logic [ExpWidth-1:0] ExpBias = 11'h3ff;

	// Decoded operand carried from the first stage.
	typedef struct packed {
		logic                 sign;
		logic                 big;     // unbiased exponent 52 or more
		logic                 tiny;    // unbiased exponent negative
		logic                 nan;
		logic [5:0]           e;       // unbiased exponent, 0..51 when used
		logic [MantWidth-1:0] mask;    // fraction bit mask
	} dec_t;

endpackage

// ===== hw/rtl/dbl_split_lzc.sv =====
// Leading-one position of a 52-bit remainder, as a pure function module.
module dbl_split_lzc
	import dbl_split_pkg::*;
(
	input  logic [MantWidth-1:0] rem,
	output logic [5:0]           pos
);
	always_comb begin
		pos = '0;
		for (int i = 0; i < int'(MantWidth); i++) begin
			if (rem[i]) begin
				pos = 6'(i);
			end
		end
	end
endmodule

// ===== hw/rtl/double_integer_fraction_split.sv =====
// Each accepted item passes through the stage registers s1, s2 and s3; the result is valid once it reaches s3.
// Throughput one item per cycle while the output is not stalled; decode, leading-one search, then normalise and pack.
// A stall on the output holds every stage whose successor is full; bubbles are squeezed out.
// Reset clears the valid bits of all stages asynchronously; payload registers are not reset.
module double_integer_fraction_split
	import dbl_split_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 valid_in,
	output logic                 ready_in,
	input  logic [WordWidth-1:0] value_bits,
	output logic                 valid_out,
	input  logic                 ready_out,
	output logic [WordWidth-1:0] whole_bits,
	output logic [WordWidth-1:0] fraction_bits
);
	logic                 v_s1, v_s2, v_s3;
	logic [WordWidth-1:0] x_s1, x_s2;
	dec_t                 d_s1, d_s2;
	logic [MantWidth-1:0] rem_s2;
	logic [5:0]           p_s2, p_c;
	logic                 en1, en2, en3;
	dec_t                 d_c;
	logic signed [12:0]   ue;

	assign en3 = !v_s3 || ready_out;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign ready_in  = en1;
	assign valid_out = v_s3;

	always_comb begin
		ue = $signed({2'b00, value_bits[62:52]}) - $signed({2'b00, ExpBias});
		d_c.sign  = value_bits[63];
		d_c.big   = ue >= 13'sd52;
		d_c.tiny  = ue < 13'sd0;
		d_c.nan   = (&value_bits[62:52]) && (|value_bits[51:0]);
		d_c.e     = ue[5:0];
		d_c.mask  = {MantWidth{1'b1}} >> ue[5:0];
	end

	dbl_split_lzc u_lzc (
		.rem (x_s1[MantWidth-1:0] & d_s1.mask),
		.pos (p_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) v_s1 <= valid_in;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			x_s1 <= value_bits;
			d_s1 <= d_c;
		end
		if (en2) begin
			x_s2   <= x_s1;
			d_s2   <= d_s1;
			rem_s2 <= x_s1[MantWidth-1:0] & d_s1.mask;
			p_s2   <= p_c;
		end
		if (en3) begin
			if (d_s2.nan) begin
				whole_bits    <= x_s2;
				fraction_bits <= x_s2;
			end else if (d_s2.big) begin
				whole_bits    <= x_s2;
				fraction_bits <= {d_s2.sign, 63'd0};
			end else if (d_s2.tiny) begin
				whole_bits    <= {d_s2.sign, 63'd0};
				fraction_bits <= x_s2;
			end else if (rem_s2 == '0) begin
				whole_bits    <= x_s2;
				fraction_bits <= {d_s2.sign, 63'd0};
			end else begin
				whole_bits    <= {x_s2[63:52], x_s2[51:0] & ~d_s2.mask};
				// Exponent is p + e + bias - 52; always a normal number.
				fraction_bits <= {d_s2.sign,
					11'(11'(p_s2) + 11'(d_s2.e) + ExpBias - 11'd52),
					52'(rem_s2 << (6'd52 - p_s2))};
			end
		end
	end
endmodule

// ===== dv/double_integer_fraction_split_test.sv =====
// Self-checking testbench for the binary64 integer/fraction split pipeline.
module double_integer_fraction_split_test;
	import dbl_split_pkg::*;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 valid_in = 1'b0;
	logic                 ready_in;
	logic [WordWidth-1:0] value_bits = '0;
	logic                 valid_out;
	logic                 ready_out = 1'b0;
	logic [WordWidth-1:0] whole_bits;
	logic [WordWidth-1:0] fraction_bits;

	typedef struct packed {
		logic [WordWidth-1:0] whole;
		logic [WordWidth-1:0] frac;
	} split_t;

	logic [WordWidth-1:0] pending_ops[$];
	split_t               expected_splits[$];
	int                   mismatches = 0;
	int                   unexpected = 0;
	bit                   stimulus_done = 1'b0;
	int                   cycle_count = 0;
	int                   hold_count = 0;
	int                   hold_start = 200;
	int                   hold_len = 120;
	bit                   calm = 1'b0;
	bit                   in_taken = 1'b0;

	double_integer_fraction_split u_dut (
		.clk(clk), .arst_n(arst_n), .valid_in(valid_in), .ready_in(ready_in),
		.value_bits(value_bits), .valid_out(valid_out), .ready_out(ready_out),
		.whole_bits(whole_bits), .fraction_bits(fraction_bits)
	);

	always #1 clk = ~clk;

	function automatic split_t modf_split(input logic [63:0] x);
		split_t      r;
		int          ex;
		logic [63:0] sign, msk, rem;
		int          top;
		ex = int'(x[62:52]) - 1023;
		sign = {x[63], 63'b0};
		top = 0;
		if (ex >= 52) begin
			r.whole = x;
			r.frac = (ex == 1024 && x[51:0] != 0) ? x : sign;
		end else if (ex < 0) begin
			r.whole = sign;
			r.frac = x;
		end else begin
			msk = 64'h000f_ffff_ffff_ffff >> ex;
			rem = x & msk;
			if (rem == 0) begin
				r.whole = x;
				r.frac = sign;
			end else begin
				r.whole = x & ~msk;
				for (int i = 0; i < 64; i++)
					if (rem[i]) top = i;
				r.frac = sign | (64'(top + ex + 1023 - 52) << 52)
					| ((rem << (52 - top)) & 64'h000f_ffff_ffff_ffff);
			end
		end
		return r;
	endfunction

	function automatic logic [63:0] random_operand();
		logic [63:0] v;
		int          ex;
		v = {$urandom, $urandom};
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: begin
				// Mostly the general case, where a fraction survives.
				ex = $urandom_range(0, 51);
				v[62:52] = 11'(1023 + ex);
				if ($urandom_range(0, 3) == 0)
					v[51:0] = v[51:0] & ~(52'hf_ffff_ffff_ffff >> ex)
						| (52'h1 << $urandom_range(0, 51 - ex));
			end
			6: v[62:52] = 11'($urandom_range(1023 + 52, 2047));
			7: v[62:52] = 11'($urandom_range(0, 1022));
			8: begin
				ex = $urandom_range(0, 51);
				v[62:52] = 11'(1023 + ex);
				v[51:0] = v[51:0] & ~(52'hf_ffff_ffff_ffff >> ex);
			end
			default: ;
		endcase
		return v;
	endfunction

	initial begin
		logic [63:0] directed[$];
		directed = '{64'h0, 64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001,
			64'h800f_ffff_ffff_ffff, 64'h7ff0_0000_0000_0000, 64'hfff0_0000_0000_0000,
			64'h7ff8_0000_0000_0000, 64'hfff0_0000_0000_0001, 64'hffff_ffff_ffff_ffff,
			64'h3ff0_0000_0000_0000, 64'h3ff0_0000_0000_0001, 64'hbff8_0000_0000_0000,
			64'h3fef_ffff_ffff_ffff, 64'h4330_0000_0000_0000, 64'h432f_ffff_ffff_ffff,
			64'hc32f_ffff_ffff_ffff, 64'h400c_0000_0000_0000, 64'h7fef_ffff_ffff_ffff,
			64'h4009_21fb_5444_2d18, 64'hc009_21fb_5444_2d18, 64'h3fe0_0000_0000_0000};
		foreach (directed[i]) pending_ops.push_back(directed[i]);
		repeat (1750) pending_ops.push_back(random_operand());
		repeat (2) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
	end

	// A calm window with no idling on either side.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		calm <= (cycle_count > 600 && cycle_count < 1100);
	end

	// Requests are taken at the rising edge, so the scoreboard is fed there.
	always @(posedge clk) begin
		in_taken <= arst_n && valid_in && ready_in;
		if (arst_n && valid_in && ready_in)
			expected_splits.push_back(modf_split(value_bits));
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (!valid_in || in_taken) begin
				if (pending_ops.size() != 0 && (calm || $urandom_range(0, 99) >= 15)) begin
					valid_in <= 1'b1;
					value_bits <= pending_ops.pop_front();
				end else begin
					valid_in <= 1'b0;
					if (pending_ops.size() == 0) stimulus_done <= 1'b1;
				end
			end
		end
	end

	// The receiver holds off for a long stretch once so that the pipeline backs up.
	always @(negedge clk) begin
		hold_count <= hold_count + 1;
		if (hold_count >= hold_start && hold_count < hold_start + hold_len)
			ready_out <= 1'b0;
		else
			ready_out <= calm || $urandom_range(0, 99) >= 15;
	end

	always @(posedge clk) begin
		split_t exp_split;
		if (arst_n && valid_out && ready_out) begin
			if (expected_splits.size() == 0) begin
				unexpected++;
				if (mismatches + unexpected <= 10)
					$display("result with no request outstanding: %h %h",
						whole_bits, fraction_bits);
			end else begin
				exp_split = expected_splits.pop_front();
				if (exp_split.whole !== whole_bits || exp_split.frac !== fraction_bits) begin
					mismatches++;
					if (mismatches + unexpected <= 10)
						$display("split mismatch: expected %h %h, got %h %h",
							exp_split.whole, exp_split.frac, whole_bits, fraction_bits);
				end
			end
		end
	end

	initial begin
		wait (stimulus_done);
		wait (expected_splits.size() == 0);
		repeat (10) @(posedge clk);
		if (mismatches == 0 && unexpected == 0 && expected_splits.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#200000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/dbl_split_pkg.sv
hw/rtl/dbl_split_lzc.sv
hw/rtl/double_integer_fraction_split.sv
dv/double_integer_fraction_split_test.sv
